/* hw/rtl/nsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg - NMEA sentence framer shared definitions
// Parse phases, report types, the sentence-type name table and helpers.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam int MAX_SENTENCE_DFLT = 81;
  localparam int MAX_ADDRESS_DFLT  = 10;

  localparam int TYPE_W   = 3;
  localparam int LEN_W    = 7;
  localparam int ALEN_W   = 4;
  localparam int NUM_TYPES = 6;
  localparam int NAME_LEN  = 5;
  localparam int POS_W     = 3;

  typedef logic [7:0] char_t;

  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;

  localparam logic [TYPE_W-1:0] TYPE_OTHER = 3'd0;

  // Known address names, in report code order (code = index + 1).
  localparam char_t TYPE_NAMES [NUM_TYPES][NAME_LEN] = '{
    '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41},  // GPGGA
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // GPGSA
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h56},  // GPGSV
    '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h42},  // GPRMB
    '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},  // GPRMC
    '{8'h47, 8'h50, 8'h5A, 8'h44, 8'h41}   // GPZDA
  };

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_DATA,
    PH_CK1,
    PH_CK2,
    PH_WAIT
  } phase_t;

  // Letter-match control from the parser to the type matcher.
  typedef struct packed {
    logic             clear;
    logic             write;
    logic [POS_W-1:0] pos;
    char_t            ch;
    logic             five;
  } match_ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic              checked;
    logic [7:0]        xsum;
    logic [ALEN_W-1:0] addr_len;
  } frame_t;

  typedef struct packed {
    logic [TYPE_W-1:0] sent_type;
    frame_t            frame;
  } report_t;

  function automatic logic is_hex(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(input char_t c);
    logic [3:0] v;
    if (c <= 8'h39) v = c[3:0];
    else            v = c[3:0] + 4'd9;
    return v;
  endfunction

endpackage

/* hw/rtl/nsf_rx_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_rx_if - received byte channel
// Valid/ready channel carrying one serial character per request.
// ----------------------------------------------------------------------------
interface nsf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/nsf_rpt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_rpt_if - sentence report channel
// Valid/ready channel carrying one report per completed sentence.
// ----------------------------------------------------------------------------
interface nsf_rpt_if;
  import nsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] sentence_type;
  logic [LEN_W-1:0]  sentence_length;
  logic              checksum_checked;
  logic [7:0]        computed_checksum;
  logic [ALEN_W-1:0] address_length;

  modport source (output valid, output sentence_type, output sentence_length,
                  output checksum_checked, output computed_checksum,
                  output address_length, input ready);
  modport sink   (input valid, input sentence_type, input sentence_length,
                  input checksum_checked, input computed_checksum,
                  input address_length, output ready);
endinterface

/* hw/rtl/nsf_type_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_type_match - address name matcher
// Keeps one match flag per known name, narrowed letter by letter.
// ----------------------------------------------------------------------------
module nsf_type_match (
  input  logic                      clk,
  input  logic                      rst,
  input  nsf_pkg::match_ctl_t       ctl,
  output logic [nsf_pkg::TYPE_W-1:0] sent_type
);
  import nsf_pkg::*;

  logic [NUM_TYPES-1:0] hit;
  logic [NUM_TYPES-1:0] hit_next;

  always_comb begin
    hit_next = hit;
    if (ctl.clear) begin
      hit_next = '1;
    end else if (ctl.write) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        hit_next[t] = hit[t] && (ctl.ch == TYPE_NAMES[t][ctl.pos]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= '1;
    end else begin
      hit <= hit_next;
    end
  end

  // first surviving name wins; only a five-letter address can match
  always_comb begin
    sent_type = TYPE_OTHER;
    if (ctl.five) begin
      for (int t = NUM_TYPES - 1; t >= 0; t--) begin
        if (hit[t]) sent_type = TYPE_W'(t + 1);
      end
    end
  end

endmodule

/* hw/rtl/nsf_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_parse - sentence framing state machine
// Phase, byte count, letter count and running checksum, one byte a cycle while fire is set.
// ----------------------------------------------------------------------------
module nsf_parse #(
  parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DFLT,
  parameter int MAX_ADDRESS  = nsf_pkg::MAX_ADDRESS_DFLT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  nsf_pkg::char_t      ch,
  output nsf_pkg::match_ctl_t mctl,
  output logic                done,
  output nsf_pkg::frame_t     frame
);
  import nsf_pkg::*;

  localparam int CW = $clog2(MAX_SENTENCE);
  localparam int LW = $clog2(MAX_ADDRESS);

  phase_t          phase, phase_next;
  logic [CW-1:0]   count, count_next;
  logic [LW-1:0]   letters, letters_next;
  logic [7:0]      xsum, xsum_next;
  logic [3:0]      high, high_next;
  logic            seen, seen_next;

  logic            is_upper;
  logic            full;

  assign is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
  assign full     = (count >= CW'(MAX_SENTENCE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      count   <= '0;
      letters <= '0;
      xsum    <= '0;
      high    <= '0;
      seen    <= 1'b0;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      letters <= letters_next;
      xsum    <= xsum_next;
      high    <= high_next;
      seen    <= seen_next;
    end
  end

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    letters_next = letters;
    xsum_next    = xsum;
    high_next    = high;
    seen_next    = seen;
    done         = 1'b0;
    mctl.clear   = 1'b0;
    mctl.write   = 1'b0;
    mctl.pos     = POS_W'(letters);
    mctl.ch      = ch;
    mctl.five    = (letters == LW'(NAME_LEN));

    if (fire) begin
      if (phase == PH_HUNT) begin
        if (ch == CH_DOLLAR) begin
          count_next   = '0;
          letters_next = '0;
          xsum_next    = '0;
          high_next    = '0;
          seen_next    = 1'b0;
          mctl.clear   = 1'b1;
          phase_next   = PH_ADDR;
        end
      end else if (full) begin
        phase_next = PH_HUNT;
      end else begin
        unique case (phase)
          PH_ADDR: begin
            count_next = count + 1'b1;
            xsum_next  = xsum ^ ch;
            if (ch == CH_COMMA) begin
              phase_next = PH_DATA;
            end else if (letters >= LW'(MAX_ADDRESS - 1) || !is_upper) begin
              phase_next = PH_HUNT;
            end else begin
              mctl.write   = (letters < LW'(NAME_LEN));
              letters_next = letters + 1'b1;
            end
          end
          PH_DATA: begin
            if (ch == CH_CR) begin
              done       = 1'b1;
              phase_next = PH_HUNT;
            end else begin
              count_next = count + 1'b1;
              if (ch == CH_STAR)    phase_next = PH_CK1;
              else if (ch == CH_LF) phase_next = PH_WAIT;
              else                  xsum_next  = xsum ^ ch;
            end
          end
          PH_CK1: begin
            if (is_hex(ch)) begin
              count_next = count + 1'b1;
              high_next  = hex_nibble(ch);
              phase_next = PH_CK2;
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_CK2: begin
            if (is_hex(ch)) begin
              count_next = count + 1'b1;
              if ({high, hex_nibble(ch)} == xsum) begin
                seen_next  = 1'b1;
                phase_next = PH_WAIT;
              end else begin
                phase_next = PH_HUNT;
              end
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_WAIT: begin
            if (ch == CH_CR) begin
              done       = 1'b1;
              phase_next = PH_HUNT;
            end else if (ch != CH_LF) begin
              phase_next = PH_HUNT;
            end
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  // final CR is counted in the report; sum taken at report width
  assign frame.length   = LEN_W'(count) + LEN_W'(1);
  assign frame.checked  = seen;
  assign frame.xsum     = xsum;
  assign frame.addr_len = ALEN_W'(letters);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SENTENCE - 1))
    else $error("byte count beyond sentence limit");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    done |-> (phase == PH_DATA || phase == PH_WAIT))
    else $error("sentence completed outside data or CR wait");

  a_start: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_HUNT && ch == CH_DOLLAR |=>
      phase == PH_ADDR && count == '0 && letters == '0 && xsum == '0)
    else $error("start character did not open a clean sentence");

endmodule

/* hw/rtl/nmea_sentence_framer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core - NMEA 0183 sentence framer
// Frames '$'-led sentences from a byte stream and reports each one.
// ----------------------------------------------------------------------------
// Usage:
//  - rx carries one received character per request (rx_byte). The core takes
//    one byte every cycle while the report register is empty or being read.
//  - rpt carries one report per sentence ended by CR: type code (0 other,
//    1..6 for GPGGA, GPGSA, GPGSV, GPRMB, GPRMC, GPZDA), length after '$'
//    including the CR, checksum match flag, XOR of the checksummed bytes and
//    the address letter count.
//  - Latency: the report is valid the cycle after the CR is taken.
//  - Throughput: one byte per cycle while rx.ready is high; the framing state is updated by a single
//    level of compares and an XOR from the registered state.
//  - A malformed sentence, or one that reaches the byte limit, gives no report;
//    the core silently goes back to looking for '$'.
//  - When the receiver stalls, the report is held and rx.ready drops only
//    while a held report is not being taken; no byte or report is lost.
//  - Reset (rst, synchronous) empties the report register and returns the
//    framer to looking for '$'.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_core #(
  parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DFLT,
  parameter int MAX_ADDRESS  = nsf_pkg::MAX_ADDRESS_DFLT
) (
  input logic       clk,
  input logic       rst,
  nsf_rx_if.sink    rx,
  nsf_rpt_if.source rpt
);
  import nsf_pkg::*;

  logic              fire;
  logic              done;
  match_ctl_t        mctl;
  frame_t            frame;
  logic [TYPE_W-1:0] sent_type;

  logic              rpt_valid;
  report_t           rpt_data;

  // byte accepted whenever the report slot is free or freeing this cycle
  assign rx.ready = !rpt_valid || rpt.ready;
  assign fire     = rx.valid && rx.ready;

  nsf_parse #(
    .MAX_SENTENCE (MAX_SENTENCE),
    .MAX_ADDRESS  (MAX_ADDRESS)
  ) u_parse (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .ch    (rx.rx_byte),
    .mctl  (mctl),
    .done  (done),
    .frame (frame)
  );

  nsf_type_match u_match (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .sent_type (sent_type)
  );

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (done) begin
      rpt_valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rpt_data.sent_type <= sent_type;
      rpt_data.frame     <= frame;
    end
  end

  assign rpt.valid             = rpt_valid;
  assign rpt.sentence_type     = rpt_data.sent_type;
  assign rpt.sentence_length   = rpt_data.frame.length;
  assign rpt.checksum_checked  = rpt_data.frame.checked;
  assign rpt.computed_checksum = rpt_data.frame.xsum;
  assign rpt.address_length    = rpt_data.frame.addr_len;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done && rpt_valid |-> rpt.ready)
    else $error("report overwritten before it was taken");

  a_min_length: assert property (@(posedge clk) disable iff (rst)
    rpt.valid |-> rpt.sentence_length >= LEN_W'(2))
    else $error("report shorter than address comma and CR");

  a_named_five: assert property (@(posedge clk) disable iff (rst)
    rpt.valid && rpt.sentence_type != TYPE_OTHER |-> rpt.address_length == ALEN_W'(NAME_LEN))
    else $error("named sentence type without a five-letter address");

endmodule
